// ===== design/cdm_pkg.sv =====
// Shared types, constants and the arctangent table of the concentric disk mapping.
package cdm_pkg;

	localparam int IN_FRAC_BITS  = 16;
	localparam int OUT_FRAC_BITS = 15;
	localparam int WORK_BITS     = 30;
	localparam int DIV_STEPS     = 30;
	localparam int CORDIC_STEPS  = 30;
	localparam int PIPE_DEPTH    = DIV_STEPS + CORDIC_STEPS + 2;

	localparam logic [29:0] PI4_Q30         = 30'd843314857;
	localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;

	typedef enum logic [1:0] {
		SEC_0 = 2'd0,
		SEC_2 = 2'd1,
		SEC_4 = 2'd2,
		SEC_6 = 2'd3
	} sector_t;

	typedef struct packed {
		sector_t     sec;
		logic        neg;
		logic [16:0] r;
	} side_t;

	typedef struct packed {
		logic [17:0] rem;
		logic [16:0] den;
		logic [30:0] quo;
		side_t       side;
	} div_t;

	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [31:0] z;
		sector_t            sec;
	} cor_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] v;
		unique case (i)
			5'd0:  v = 30'd843314857;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043837;
			5'd3:  v = 30'd133525159;
			5'd4:  v = 30'd67021687;
			5'd5:  v = 30'd33543516;
			5'd6:  v = 30'd16775851;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194283;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048576;
			5'd11: v = 30'd524288;
			5'd12: v = 30'd262144;
			5'd13: v = 30'd131072;
			5'd14: v = 30'd65536;
			5'd15: v = 30'd32768;
			5'd16: v = 30'd16384;
			5'd17: v = 30'd8192;
			5'd18: v = 30'd4096;
			5'd19: v = 30'd2048;
			5'd20: v = 30'd1024;
			5'd21: v = 30'd512;
			5'd22: v = 30'd256;
			5'd23: v = 30'd128;
			5'd24: v = 30'd64;
			5'd25: v = 30'd32;
			5'd26: v = 30'd16;
			5'd27: v = 30'd8;
			5'd28: v = 30'd4;
			5'd29: v = 30'd2;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== design/cdm_in_if.sv =====
// Input channel carrying one unit-square sample per transfer.
interface cdm_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] square_x;
	logic [15:0] square_y;

	modport source(output valid, output square_x, output square_y, input ready);
	modport sink(input valid, input square_x, input square_y, output ready);
endinterface

// ===== design/cdm_out_if.sv =====
// Output channel carrying one disk point per transfer.
interface cdm_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] disk_x;
	logic signed [15:0] disk_y;

	modport source(output valid, output disk_x, output disk_y, input ready);
	modport sink(input valid, input disk_x, input disk_y, output ready);
endinterface

// ===== design/cdm_div_cell.sv =====
// One restoring division cell that produces one quotient bit per stage.
module cdm_div_cell
	import cdm_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  div_t d_in,
	output div_t d_out
);

	logic [17:0] rem2;
	logic        take;
	div_t        nxt;

	always_comb begin
		rem2       = {d_in.rem[16:0], 1'b0};
		take       = rem2 >= {1'b0, d_in.den};
		nxt        = d_in;
		nxt.rem    = take ? rem2 - {1'b0, d_in.den} : rem2;
		nxt.quo    = {d_in.quo[29:0], take};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

// ===== design/cdm_cordic_cell.sv =====
// One CORDIC rotation cell with a fixed step index.
module cdm_cordic_cell
	import cdm_pkg::*;
(
	input  logic       clk,
	input  logic       en,
	input  logic [4:0] step,
	input  cor_t       d_in,
	output cor_t       d_out
);

	logic signed [32:0] dx;
	logic signed [32:0] dy;
	logic signed [31:0] ang;
	cor_t               nxt;

	always_comb begin
		dx  = d_in.y >>> step;
		dy  = d_in.x >>> step;
		ang = $signed({2'b00, atan_q30(step)});
		nxt = d_in;
		if (d_in.z >= 0) begin
			nxt.x = d_in.x - dx;
			nxt.y = d_in.y + dy;
			nxt.z = d_in.z - ang;
		end else begin
			nxt.x = d_in.x + dx;
			nxt.y = d_in.y - dy;
			nxt.z = d_in.z + ang;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end

endmodule

// ===== design/concentric_disk_map.sv =====
// Top level of the concentric square-to-disk mapping pipeline.
// Usage: each transfer on the sample channel carries one point of the unit
// square (square_x, square_y, unsigned Q0.16). Each transfer on the point
// channel carries the matching point of the unit disk (disk_x, disk_y,
// signed Q1.15, with +1 saturated to 32767), in the same order.
// Throughput is one sample per cycle while the point channel does not stall,
// with no dependence between samples. Between the sample transfer and the
// point becoming valid lie one sector stage, 30 division cells, one multiplier
// stage, 30 CORDIC cells and the output register.
// The whole pipeline advances in a cycle in which the output register is
// empty or its point is taken. When the receiver stalls, ready on the sample
// channel drops and every stage holds its contents; no point is lost.
// Reset clears all valid flags at once; the block accepts samples in the
// first cycle after reset is released.
module concentric_disk_map
	import cdm_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	cdm_in_if.sink          sample,
	cdm_out_if.source       point
);

	logic                  en;
	logic [PIPE_DEPTH-1:0] valid_q;
	logic                  out_valid_q;

	logic signed [17:0] a;
	logic signed [17:0] b;
	logic signed [18:0] sum_ab;
	logic signed [17:0] num;
	logic signed [17:0] den;
	logic [16:0]        abs_n;
	logic [16:0]        abs_d;
	logic               q_top;
	div_t               prep;
	div_t               div_s1;
	div_t               div_chain [DIV_STEPS+1];

	logic [60:0] prod_a;
	logic [60:0] ang_sum;
	logic [46:0] prod_r;
	logic [46:0] x_sum;
	cor_t        mul_nxt;
	cor_t        cor_chain [CORDIC_STEPS+1];

	logic signed [32:0] rx;
	logic signed [32:0] ry;
	logic signed [15:0] disk_x_q;
	logic signed [15:0] disk_y_q;

	function automatic logic signed [15:0] to_out(input logic signed [32:0] v);
		localparam int SH = WORK_BITS - OUT_FRAC_BITS;
		logic signed [33:0] s;
		logic signed [33:0] q;
		logic signed [15:0] o;
		s = 34'(v) + (34'sd1 <<< (SH - 1));
		q = s >>> SH;
		if (q > 34'sd32767) begin
			o = 16'sh7FFF;
		end else if (q < -34'sd32768) begin
			o = 16'sh8000;
		end else begin
			o = q[15:0];
		end
		return o;
	endfunction

	assign en           = !out_valid_q || point.ready;
	assign sample.ready = en;

	always_comb begin
		a      = $signed({1'b0, sample.square_x, 1'b0}) - 18'sd65536;
		b      = $signed({1'b0, sample.square_y, 1'b0}) - 18'sd65536;
		sum_ab = 19'(a) + 19'(b);
		prep   = '0;
		if (sum_ab > 0) begin
			if (a > b) begin
				num = b; den = a; prep.side.neg = b < 0; prep.side.sec = SEC_0;
			end else begin
				num = a; den = b; prep.side.neg = a > 0; prep.side.sec = SEC_2;
			end
		end else begin
			if (a < b) begin
				num = b; den = a; prep.side.neg = b > 0; prep.side.sec = SEC_4;
			end else begin
				num = a; den = b; prep.side.neg = a < 0; prep.side.sec = SEC_6;
			end
		end
		abs_n = num < 0 ? 17'(-num) : 17'(num);
		abs_d = den < 0 ? 17'(-den) : 17'(den);
		prep.side.r = abs_d;
		if (abs_d == '0) begin
			abs_n         = '0;
			abs_d         = 17'd1;
			prep.side.r   = '0;
			prep.side.sec = SEC_0;
			prep.side.neg = 1'b0;
		end
		q_top    = abs_n >= abs_d;
		prep.den = abs_d;
		prep.rem = q_top ? 18'(abs_n - abs_d) : 18'(abs_n);
		prep.quo = {30'd0, q_top};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_q     <= {valid_q[PIPE_DEPTH-2:0], sample.valid};
			out_valid_q <= valid_q[PIPE_DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s1 <= prep;
		end
	end

	assign div_chain[0] = div_s1;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		cdm_div_cell u_cell (
			.clk   (clk),
			.en    (en),
			.d_in  (div_chain[i]),
			.d_out (div_chain[i+1])
		);
	end

	always_comb begin
		prod_a      = {30'd0, div_chain[DIV_STEPS].quo} * {31'd0, PI4_Q30};
		ang_sum     = prod_a + (61'd1 << (WORK_BITS - 1));
		prod_r      = {30'd0, div_chain[DIV_STEPS].side.r} * {17'd0, CORDIC_GAIN_Q30};
		x_sum       = prod_r + (47'd1 << (WORK_BITS - 1 - (WORK_BITS - IN_FRAC_BITS)));
		mul_nxt.sec = div_chain[DIV_STEPS].side.sec;
		mul_nxt.y   = '0;
		mul_nxt.x   = $signed({2'b00, x_sum[46:IN_FRAC_BITS]});
		mul_nxt.z   = div_chain[DIV_STEPS].side.neg ? -$signed({1'b0, ang_sum[60:30]})
		                                           :  $signed({1'b0, ang_sum[60:30]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cor_chain[0] <= mul_nxt;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		cdm_cordic_cell u_cell (
			.clk   (clk),
			.en    (en),
			.step  (5'(i)),
			.d_in  (cor_chain[i]),
			.d_out (cor_chain[i+1])
		);
	end

	always_comb begin
		unique case (cor_chain[CORDIC_STEPS].sec)
			SEC_2: begin
				rx = -cor_chain[CORDIC_STEPS].y; ry = cor_chain[CORDIC_STEPS].x;
			end
			SEC_4: begin
				rx = -cor_chain[CORDIC_STEPS].x; ry = -cor_chain[CORDIC_STEPS].y;
			end
			SEC_6: begin
				rx = cor_chain[CORDIC_STEPS].y; ry = -cor_chain[CORDIC_STEPS].x;
			end
			default: begin
				rx = cor_chain[CORDIC_STEPS].x; ry = cor_chain[CORDIC_STEPS].y;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			disk_x_q <= to_out(rx);
			disk_y_q <= to_out(ry);
		end
	end

	assign point.valid  = out_valid_q;
	assign point.disk_x = disk_x_q;
	assign point.disk_y = disk_y_q;

`ifndef NO_ASSERTIONS
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[0] |-> div_s1.den != '0)
		else $error("divisor is zero after the sector stage");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[DIV_STEPS] |-> div_chain[DIV_STEPS].rem < {1'b0, div_chain[DIV_STEPS].den})
		else $error("division remainder not below divisor");

	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[DIV_STEPS] |-> div_chain[DIV_STEPS].quo <= (31'd1 << WORK_BITS))
		else $error("slope ratio above one");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !point.ready) |=> $stable(valid_q) && out_valid_q)
		else $error("pipeline advanced during a stall");
`endif

endmodule
